// ===== design/miv_pkg.sv =====
`default_nettype none

package miv_pkg;

    // Position arithmetic
    localparam int POSITION_BITS = 32;
    localparam int DIFF_W        = POSITION_BITS + 1;
    localparam int PROD_W        = 2 * DIFF_W;
    localparam int CROSS_W       = PROD_W + 1;
    // A cross component at or above 2^MAG_W squares past any threshold
    localparam int MAG_W         = 32;
    localparam int SQ_W          = 2 * MAG_W;

    // Field and register widths
    localparam int IDX_W      = 32;
    localparam int DEG_W      = 31;
    localparam int THR_W      = 63;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = THR_W;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POSITIONS_AVL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AREA_THRESHOLD = 2'd2;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(18446744);

    typedef logic signed [DIFF_W-1:0] t_diff;

    // One classified index, handed from the front end to the area unit
    typedef struct packed {
        logic [IDX_W-1:0] min_index;
        logic [IDX_W-1:0] max_index;
        logic [IDX_W-1:0] range_count;
        logic             clear_deg;
        logic             done;
        logic             eq_degen;
        logic             need_area;
        t_diff            ax;
        t_diff            ay;
        t_diff            az;
        t_diff            bx;
        t_diff            by;
        t_diff            bz;
    } t_entry;

endpackage

`default_nettype wire

// ===== design/mesh_index_validator_unit.sv =====
// Mesh index validator: checks an index buffer stream for range errors and
// degenerate triangles.
//
// Input channel (i_in_valid / o_in_ready): one index per request with the
// fetched position of its vertex (signed Q16.16). i_first_of_mesh clears all
// statistics and restarts triangle grouping. Output channel (o_out_valid /
// i_out_ready): one result per index with running min/max index, range error
// count, degenerate triangle count and whether this index closed a
// (degenerate) triangle. Configuration is written through i_cfg_we,
// i_cfg_index and i_cfg_data while the block is idle.
//
// When no area test is needed, a result passes through the queue and the
// output register; such indices stream at one per cycle while the back end
// is idle and the receiver ready. The area test uses one multiplier forming
// six cross products in turn and a second forming three squares in turn.
// A two-entry queue decouples the front end from the back end; while the area
// test runs or the receiver stalls, the result register holds, the queue
// fills, then o_in_ready drops. Reset empties the queue and output register
// and restores register defaults.

`default_nettype none

module mesh_index_validator_unit (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_we,
    input  wire  [miv_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire  [miv_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  wire                                  i_in_valid,
    output logic                                 o_in_ready,
    input  wire                                  i_first_of_mesh,
    input  wire  [miv_pkg::IDX_W-1:0]            i_vertex_index,
    input  wire  signed [31:0]                   i_pos_x,
    input  wire  signed [31:0]                   i_pos_y,
    input  wire  signed [31:0]                   i_pos_z,
    output logic                                 o_out_valid,
    input  wire                                  i_out_ready,
    output logic [miv_pkg::IDX_W-1:0]            o_min_index,
    output logic [miv_pkg::IDX_W-1:0]            o_max_index,
    output logic [miv_pkg::IDX_W-1:0]            o_out_of_range_count,
    output logic [miv_pkg::DEG_W-1:0]            o_degenerate_count,
    output logic                                 o_triangle_done,
    output logic                                 o_triangle_degenerate
);

    logic [miv_pkg::IDX_W-1:0]  r_vertex_count;
    logic                       r_positions_available;
    logic [miv_pkg::THR_W-1:0]  r_area_threshold;

    logic                       w_push;
    logic                       w_full;
    logic                       w_q_valid;
    logic                       w_pop;
    miv_pkg::t_entry            w_push_entry;
    miv_pkg::t_entry            w_q_entry;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count        <= '0;
            r_positions_available <= 1'b1;
            r_area_threshold      <= miv_pkg::THR_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                miv_pkg::CFG_VERTEX_COUNT:
                    r_vertex_count <= i_cfg_data[miv_pkg::IDX_W-1:0];
                miv_pkg::CFG_POSITIONS_AVL:
                    r_positions_available <= i_cfg_data[0];
                miv_pkg::CFG_AREA_THRESHOLD:
                    r_area_threshold <= i_cfg_data[miv_pkg::THR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    miv_front u_front (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (i_in_valid),
        .o_in_ready            (o_in_ready),
        .i_first_of_mesh       (i_first_of_mesh),
        .i_vertex_index        (i_vertex_index),
        .i_pos_x               (i_pos_x),
        .i_pos_y               (i_pos_y),
        .i_pos_z               (i_pos_z),
        .i_vertex_count        (r_vertex_count),
        .i_positions_available (r_positions_available),
        .i_full                (w_full),
        .o_push                (w_push),
        .o_entry               (w_push_entry)
    );

    miv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_entry (w_q_entry)
    );

    miv_back u_back (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_q_valid             (w_q_valid),
        .i_q_entry             (w_q_entry),
        .o_pop                 (w_pop),
        .i_area_threshold      (r_area_threshold),
        .o_out_valid           (o_out_valid),
        .i_out_ready           (i_out_ready),
        .o_min_index           (o_min_index),
        .o_max_index           (o_max_index),
        .o_out_of_range_count  (o_out_of_range_count),
        .o_degenerate_count    (o_degenerate_count),
        .o_triangle_done       (o_triangle_done),
        .o_triangle_degenerate (o_triangle_degenerate)
    );

endmodule

`default_nettype wire

// ===== design/miv_front.sv =====
`default_nettype none

module miv_front (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_ready,
    input  wire                                 i_first_of_mesh,
    input  wire  [miv_pkg::IDX_W-1:0]           i_vertex_index,
    input  wire  signed [31:0]                  i_pos_x,
    input  wire  signed [31:0]                  i_pos_y,
    input  wire  signed [31:0]                  i_pos_z,
    input  wire  [miv_pkg::IDX_W-1:0]           i_vertex_count,
    input  wire                                 i_positions_available,
    input  wire                                 i_full,
    output logic                                o_push,
    output miv_pkg::t_entry                     o_entry
);

    localparam int PB = miv_pkg::POSITION_BITS;

    logic [1:0]                   r_slot;
    logic [miv_pkg::IDX_W-1:0]    r_low;
    logic [miv_pkg::IDX_W-1:0]    r_high;
    logic [miv_pkg::IDX_W-1:0]    r_range;
    logic [miv_pkg::IDX_W-1:0]    r_hidx [2];
    logic signed [PB-1:0]         r_hx [2];
    logic signed [PB-1:0]         r_hy [2];
    logic signed [PB-1:0]         r_hz [2];

    logic [1:0]                   n_slot;
    logic [miv_pkg::IDX_W-1:0]    n_low;
    logic [miv_pkg::IDX_W-1:0]    n_high;
    logic [miv_pkg::IDX_W-1:0]    n_range;

    logic [1:0]                   w_base_slot;
    logic [miv_pkg::IDX_W-1:0]    w_base_low;
    logic [miv_pkg::IDX_W-1:0]    w_base_high;
    logic [miv_pkg::IDX_W-1:0]    w_base_range;
    logic                         w_oor;
    logic                         w_done;
    logic                         w_eq;
    logic                         w_in_range;
    logic signed [PB-1:0]         w_x;
    logic signed [PB-1:0]         w_y;
    logic signed [PB-1:0]         w_z;

    assign o_in_ready = !i_full;
    assign o_push     = i_in_valid && !i_full;

    // Keep only the low position bits, read as signed
    assign w_x = $signed(i_pos_x[PB-1:0]);
    assign w_y = $signed(i_pos_y[PB-1:0]);
    assign w_z = $signed(i_pos_z[PB-1:0]);

    // Statistics update, starting from cleared values on a new mesh
    always_comb begin
        w_base_slot  = i_first_of_mesh ? 2'd0 : r_slot;
        w_base_low   = i_first_of_mesh ? '1 : r_low;
        w_base_high  = i_first_of_mesh ? '0 : r_high;
        w_base_range = i_first_of_mesh ? '0 : r_range;

        n_low  = (i_vertex_index < w_base_low)  ? i_vertex_index : w_base_low;
        n_high = (i_vertex_index > w_base_high) ? i_vertex_index : w_base_high;

        w_oor   = (i_vertex_index >= i_vertex_count);
        n_range = (w_oor && (w_base_range != '1)) ? w_base_range + 1'b1 : w_base_range;

        w_done = (w_base_slot == 2'd2);
        n_slot = w_done ? 2'd0 : w_base_slot + 2'd1;
    end

    // Classify the triangle this index may complete
    always_comb begin
        w_eq = (r_hidx[0] == r_hidx[1]) || (r_hidx[1] == i_vertex_index)
            || (i_vertex_index == r_hidx[0]);
        w_in_range = (r_hidx[0] < i_vertex_count) && (r_hidx[1] < i_vertex_count) && !w_oor;

        o_entry.min_index   = n_low;
        o_entry.max_index   = n_high;
        o_entry.range_count = n_range;
        o_entry.clear_deg   = i_first_of_mesh;
        o_entry.done        = w_done;
        o_entry.eq_degen    = w_done && w_eq;
        o_entry.need_area   = w_done && !w_eq && i_positions_available && w_in_range;
        o_entry.ax = miv_pkg::t_diff'(r_hx[1]) - miv_pkg::t_diff'(r_hx[0]);
        o_entry.ay = miv_pkg::t_diff'(r_hy[1]) - miv_pkg::t_diff'(r_hy[0]);
        o_entry.az = miv_pkg::t_diff'(r_hz[1]) - miv_pkg::t_diff'(r_hz[0]);
        o_entry.bx = miv_pkg::t_diff'(w_x) - miv_pkg::t_diff'(r_hx[0]);
        o_entry.by = miv_pkg::t_diff'(w_y) - miv_pkg::t_diff'(r_hy[0]);
        o_entry.bz = miv_pkg::t_diff'(w_z) - miv_pkg::t_diff'(r_hz[0]);
    end

    // Advance slot and statistics on each request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= 2'd0;
            r_low   <= '1;
            r_high  <= '0;
            r_range <= '0;
        end else if (o_push) begin
            r_slot  <= n_slot;
            r_low   <= n_low;
            r_high  <= n_high;
            r_range <= n_range;
        end
    end

    // Hold the first two corners of the triangle
    always_ff @(posedge i_clk) begin
        if (o_push && !w_done) begin
            r_hidx[w_base_slot[0]] <= i_vertex_index;
            r_hx[w_base_slot[0]]   <= w_x;
            r_hy[w_base_slot[0]]   <= w_y;
            r_hz[w_base_slot[0]]   <= w_z;
        end
    end

endmodule

`default_nettype wire

// ===== design/miv_queue.sv =====
`default_nettype none

module miv_queue (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  miv_pkg::t_entry  i_entry,
    output logic             o_full,
    output logic             o_valid,
    input  wire              i_pop,
    output miv_pkg::t_entry  o_entry
);

    miv_pkg::t_entry r_mem [2];
    logic            r_wptr;
    logic            r_rptr;
    logic [1:0]      r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_entry = r_mem[r_rptr];

    // Track fill level and pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    // Store the pushed entry
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

endmodule

`default_nettype wire

// ===== design/miv_back.sv =====
`default_nettype none

module miv_back (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_q_valid,
    input  miv_pkg::t_entry                  i_q_entry,
    output logic                             o_pop,
    input  wire  [miv_pkg::THR_W-1:0]        i_area_threshold,
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output logic [miv_pkg::IDX_W-1:0]        o_min_index,
    output logic [miv_pkg::IDX_W-1:0]        o_max_index,
    output logic [miv_pkg::IDX_W-1:0]        o_out_of_range_count,
    output logic [miv_pkg::DEG_W-1:0]        o_degenerate_count,
    output logic                             o_triangle_done,
    output logic                             o_triangle_degenerate
);

    localparam int CW = miv_pkg::CROSS_W;
    localparam int SW = miv_pkg::SQ_W;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_SQR  = 4'b0100,
        ST_EMIT = 4'b1000
    } t_back_state;

    t_back_state                     r_state;
    logic [2:0]                      r_step;
    miv_pkg::t_entry                 r_ent;
    logic signed [miv_pkg::PROD_W-1:0] r_prod;
    logic signed [CW-1:0]            r_cross [3];
    logic [miv_pkg::MAG_W-1:0]       r_mag;
    logic                            r_big;
    logic [SW-1:0]                   r_sq;
    logic                            r_sq_big;
    logic [SW-1:0]                   r_sum;
    logic [miv_pkg::DEG_W-1:0]       r_deg;

    logic                            r_out_valid;
    logic [miv_pkg::IDX_W-1:0]       r_min;
    logic [miv_pkg::IDX_W-1:0]       r_max;
    logic [miv_pkg::IDX_W-1:0]       r_range;
    logic                            r_done;
    logic                            r_degen;

    logic [miv_pkg::DEG_W-1:0]       n_deg;

    logic                            w_slot_free;
    logic                            w_emit_area;
    logic                            w_emit_direct;
    logic                            w_emit;
    logic                            w_load;
    miv_pkg::t_entry                 w_src;
    logic                            w_degen;
    logic [miv_pkg::DEG_W-1:0]       w_deg_base;
    miv_pkg::t_diff                  w_op_a;
    miv_pkg::t_diff                  w_op_b;
    logic signed [miv_pkg::PROD_W-1:0] w_prod;
    logic signed [CW-1:0]            w_mag_full;
    logic [SW:0]                     w_sum_ext;
    logic [SW-1:0]                   w_sum_sat;

    // Handshake with the queue and the output register
    always_comb begin
        w_slot_free   = !r_out_valid || i_out_ready;
        w_emit_area   = (r_state == ST_EMIT) && w_slot_free;
        w_emit_direct = (r_state == ST_IDLE) && i_q_valid && w_slot_free
                     && !i_q_entry.need_area;
        w_load        = (r_state == ST_IDLE) && i_q_valid && i_q_entry.need_area;
        w_emit        = w_emit_area || w_emit_direct;
        o_pop         = w_emit_direct || w_load;
    end

    // Result and degenerate count for the request being delivered
    always_comb begin
        w_src      = w_emit_area ? r_ent : i_q_entry;
        w_degen    = w_emit_area ? (r_sum <= SW'(i_area_threshold)) : i_q_entry.eq_degen;
        w_deg_base = w_src.clear_deg ? '0 : r_deg;
        n_deg      = (w_degen && (w_deg_base != '1)) ? w_deg_base + 1'b1 : w_deg_base;
    end

    // Select the product for this step of the cross product
    always_comb begin
        unique case (r_step)
            3'd0: begin w_op_a = r_ent.ay; w_op_b = r_ent.bz; end
            3'd1: begin w_op_a = r_ent.az; w_op_b = r_ent.by; end
            3'd2: begin w_op_a = r_ent.az; w_op_b = r_ent.bx; end
            3'd3: begin w_op_a = r_ent.ax; w_op_b = r_ent.bz; end
            3'd4: begin w_op_a = r_ent.ax; w_op_b = r_ent.by; end
            3'd5: begin w_op_a = r_ent.ay; w_op_b = r_ent.bx; end
            default: begin w_op_a = '0; w_op_b = '0; end
        endcase
        w_prod = w_op_a * w_op_b;
    end

    // Magnitude of the oldest cross component and saturating square sum
    always_comb begin
        w_mag_full = r_cross[0][CW-1] ? -r_cross[0] : r_cross[0];
        w_sum_ext  = {1'b0, r_sum} + {1'b0, r_sq};
        w_sum_sat  = (r_sq_big || w_sum_ext[SW]) ? '1 : w_sum_ext[SW-1:0];
    end

    // Sequencer and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= 3'd0;
            r_deg       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_deg       <= n_deg;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (w_load) begin
                        r_state <= ST_MUL;
                        r_step  <= 3'd0;
                    end
                end
                ST_MUL: begin
                    if (r_step == 3'd6) begin
                        r_state <= ST_SQR;
                        r_step  <= 3'd0;
                    end else begin
                        r_step <= r_step + 3'd1;
                    end
                end
                ST_SQR: begin
                    if (r_step == 3'd4) begin
                        r_state <= ST_EMIT;
                        r_step  <= 3'd0;
                    end else begin
                        r_step <= r_step + 3'd1;
                    end
                end
                ST_EMIT: begin
                    if (w_slot_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Area datapath: one multiplier for the products, a second for the squares
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_ent <= i_q_entry;
            r_sum <= '0;
        end

        if (r_state == ST_MUL) begin
            if (r_step != 3'd6) begin
                r_prod <= w_prod;
            end
            if (r_step != 3'd0) begin
                // even products open a component, odd ones subtract from it
                if (r_step[0]) begin
                    r_cross[0] <= r_cross[1];
                    r_cross[1] <= r_cross[2];
                    r_cross[2] <= CW'(r_prod);
                end else begin
                    r_cross[2] <= r_cross[2] - CW'(r_prod);
                end
            end
        end

        if (r_state == ST_SQR) begin
            if (r_step < 3'd3) begin
                r_mag      <= w_mag_full[miv_pkg::MAG_W-1:0];
                r_big      <= |w_mag_full[CW-1:miv_pkg::MAG_W];
                r_cross[0] <= r_cross[1];
                r_cross[1] <= r_cross[2];
            end
            if ((r_step >= 3'd1) && (r_step <= 3'd3)) begin
                r_sq     <= r_mag * r_mag;
                r_sq_big <= r_big;
            end
            if (r_step >= 3'd2) begin
                r_sum <= w_sum_sat;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_min   <= w_src.min_index;
            r_max   <= w_src.max_index;
            r_range <= w_src.range_count;
            r_done  <= w_src.done;
            r_degen <= w_degen;
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_min_index           = r_min;
    assign o_max_index           = r_max;
    assign o_out_of_range_count  = r_range;
    assign o_degenerate_count    = r_deg;
    assign o_triangle_done       = r_done;
    assign o_triangle_degenerate = r_degen;

endmodule

`default_nettype wire

// ===== design/miv_checker.sv =====
`default_nettype none

module miv_checker (
    input wire                             i_clk,
    input wire                             i_rst_n,
    input wire                             o_out_valid,
    input wire                             i_out_ready,
    input wire [miv_pkg::IDX_W-1:0]        o_min_index,
    input wire [miv_pkg::IDX_W-1:0]        o_max_index,
    input wire                             o_triangle_done,
    input wire                             o_triangle_degenerate
);

    // Reset drops any pending result
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result still valid after reset");

    // A stalled result holds
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_min_index)
            && $stable(o_max_index) && $stable(o_triangle_degenerate))
        else $error("stalled result changed");

    // Only a completed triangle can be degenerate
    a_degen_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_triangle_degenerate |-> o_triangle_done)
        else $error("degenerate flag without a completed triangle");

    // Every result has seen at least one index of its mesh
    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_min_index <= o_max_index)
        else $error("minimum index above maximum index");

endmodule

bind mesh_index_validator_unit miv_checker u_checker (.*);

`default_nettype wire

// ===== dv/mesh_index_validator_unit_tb.sv =====
module mesh_index_validator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import miv_pkg::*;

    localparam int PHASES       = 8;
    localparam int RANDOM_ITEMS = 1100;
    localparam int SETTLE_TAIL  = 32;
    // Register index past the end of the map; writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam logic signed [31:0] CORNER_VALUES [5] = '{
        32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0, -32'sd1, 32'sd1
    };

    typedef struct packed {
        logic [IDX_W-1:0] min_index;
        logic [IDX_W-1:0] max_index;
        logic [IDX_W-1:0] range_count;
        logic [DEG_W-1:0] degen_count;
        logic             done;
        logic             degenerate;
    } t_stats;

    typedef struct {
        bit                    is_reg;
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0] reg_value;
        logic                  first;
        logic [IDX_W-1:0]      vindex;
        logic signed [31:0]    px;
        logic signed [31:0]    py;
        logic signed [31:0]    pz;
        bit                    typed;
        t_stats                want;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic                  i_first_of_mesh = 1'b0;
    logic [IDX_W-1:0]      i_vertex_index = '0;
    logic signed [31:0]    i_pos_x = '0;
    logic signed [31:0]    i_pos_y = '0;
    logic signed [31:0]    i_pos_z = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [IDX_W-1:0]      o_min_index;
    logic [IDX_W-1:0]      o_max_index;
    logic [IDX_W-1:0]      o_out_of_range_count;
    logic [DEG_W-1:0]      o_degenerate_count;
    logic                  o_triangle_done;
    logic                  o_triangle_degenerate;

    mesh_index_validator_unit dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_data            (i_cfg_data),
        .i_in_valid            (i_in_valid),
        .o_in_ready            (o_in_ready),
        .i_first_of_mesh       (i_first_of_mesh),
        .i_vertex_index        (i_vertex_index),
        .i_pos_x               (i_pos_x),
        .i_pos_y               (i_pos_y),
        .i_pos_z               (i_pos_z),
        .o_out_valid           (o_out_valid),
        .i_out_ready           (i_out_ready),
        .o_min_index           (o_min_index),
        .o_max_index           (o_max_index),
        .o_out_of_range_count  (o_out_of_range_count),
        .o_degenerate_count    (o_degenerate_count),
        .o_triangle_done       (o_triangle_done),
        .o_triangle_degenerate (o_triangle_degenerate)
    );

    always #5 i_clk = ~i_clk;

    // Mirror of the block's registers and mesh statistics
    logic [IDX_W-1:0]   vtx_count;
    logic               pos_enable;
    logic [THR_W-1:0]   area_limit;
    int unsigned        tri_slot;
    logic [IDX_W-1:0]   held_vidx [2];
    logic signed [31:0] held_pos [2][3];
    logic [IDX_W-1:0]   low_idx;
    logic [IDX_W-1:0]   high_idx;
    logic [IDX_W-1:0]   range_errs;
    logic [DEG_W-1:0]   degen_total;

    t_stats pending_stats [$];
    t_row   stim_table [$];
    int     mismatch_count = 0;
    int     burst_left = 0;

    function automatic void clear_mesh_stats();
        tri_slot    = 0;
        low_idx     = '1;
        high_idx    = '0;
        range_errs  = '0;
        degen_total = '0;
    endfunction

    function automatic void note_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_VERTEX_COUNT:   vtx_count  = val[IDX_W-1:0];
            CFG_POSITIONS_AVL:  pos_enable = val[0];
            CFG_AREA_THRESHOLD: area_limit = val[THR_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic logic [SQ_W-1:0] sum_sat(logic [SQ_W-1:0] a, logic [SQ_W-1:0] b);
        logic [SQ_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SQ_W] ? {SQ_W{1'b1}} : s[SQ_W-1:0];
    endfunction

    // Square one cross component; anything at or past 2^32 pins to all ones
    function automatic logic [SQ_W-1:0] square_of(logic signed [CROSS_W-1:0] c);
        logic [CROSS_W-1:0] mag;
        logic [SQ_W-1:0]    m;
        mag = c[CROSS_W-1] ? -c : c;
        if (|mag[CROSS_W-1:MAG_W])
            return {SQ_W{1'b1}};
        m = mag[MAG_W-1:0];
        return m * m;
    endfunction

    // Saturating squared cross length against the threshold
    function automatic bit area_is_small(input logic signed [31:0] p0 [3],
                                         input logic signed [31:0] p1 [3],
                                         input logic signed [31:0] p2 [3]);
        logic signed [DIFF_W-1:0]  a [3];
        logic signed [DIFF_W-1:0]  b [3];
        logic signed [CROSS_W-1:0] cx, cy, cz;
        for (int k = 0; k < 3; k++) begin
            a[k] = p1[k] - p0[k];
            b[k] = p2[k] - p0[k];
        end
        cx = a[1] * b[2] - a[2] * b[1];
        cy = a[2] * b[0] - a[0] * b[2];
        cz = a[0] * b[1] - a[1] * b[0];
        return sum_sat(sum_sat(square_of(cx), square_of(cy)), square_of(cz))
               <= {1'b0, area_limit};
    endfunction

    // Advance the mesh statistics by one index and return the result it should produce
    function automatic t_stats advance_mesh_stats(logic first, logic [IDX_W-1:0] v,
                                                  logic signed [31:0] x, y, z);
        t_stats             r;
        logic signed [31:0] cur [3];
        bit                 degen;
        r = '0;
        degen = 1'b0;
        cur[0] = x;
        cur[1] = y;
        cur[2] = z;
        if (first)
            clear_mesh_stats();
        if (v < low_idx)
            low_idx = v;
        if (v > high_idx)
            high_idx = v;
        if (v >= vtx_count && range_errs != '1)
            range_errs++;
        if (tri_slot < 2) begin
            held_vidx[tri_slot] = v;
            held_pos[tri_slot]  = cur;
            tri_slot++;
        end else begin
            r.done = 1'b1;
            if (held_vidx[0] == held_vidx[1] || held_vidx[1] == v || v == held_vidx[0]) begin
                degen = 1'b1;
            end else if (pos_enable && held_vidx[0] < vtx_count && held_vidx[1] < vtx_count
                         && v < vtx_count) begin
                degen = area_is_small(held_pos[0], held_pos[1], cur);
            end
            if (degen && degen_total != '1)
                degen_total++;
            tri_slot = 0;
        end
        r.min_index   = low_idx;
        r.max_index   = high_idx;
        r.range_count = range_errs;
        r.degen_count = degen_total;
        r.degenerate  = degen;
        return r;
    endfunction

    function automatic logic [IDX_W-1:0] rand_index();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 70 && vtx_count != 0)
            return $urandom_range(0, vtx_count - 1);
        if (pick < 90)
            return vtx_count + $urandom_range(0, 3) - 2;
        return $urandom;
    endfunction

    function automatic void row_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        t_row e;
        e = '{default: '0};
        e.is_reg    = 1'b1;
        e.reg_index = idx;
        e.reg_value = val;
        stim_table.push_back(e);
    endfunction

    function automatic void row_idx(logic first, logic [IDX_W-1:0] v,
                                    logic signed [31:0] x, y, z,
                                    bit typed = 1'b0, t_stats want = '0);
        t_row e;
        e = '{default: '0};
        e.first  = first;
        e.vindex = v;
        e.px     = x;
        e.py     = y;
        e.pz     = z;
        e.typed  = typed;
        e.want   = want;
        stim_table.push_back(e);
    endfunction

    function automatic void flag_failure(string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s", msg);
    endfunction

    // Drop valid and hold until every outstanding request has been answered
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (pending_stats.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        wait_for_results();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        note_reg(idx, val);
        @(posedge i_clk);
    endtask

    // Present one index request; bursts of back-to-back requests with gaps between
    task automatic send_request(input logic first, input logic [IDX_W-1:0] v,
                                input logic signed [31:0] x, y, z,
                                input bit typed, input t_stats want);
        t_stats predicted;
        i_cfg_we <= 1'b0;
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(0, 3) == 0 ? $urandom_range(8, 30) : $urandom_range(1, 4))
                @(posedge i_clk);
            burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 10);
        end
        burst_left--;
        i_in_valid      <= 1'b1;
        i_first_of_mesh <= first;
        i_vertex_index  <= v;
        i_pos_x         <= x;
        i_pos_y         <= y;
        i_pos_z         <= z;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = advance_mesh_stats(first, v, x, y, z);
        pending_stats.push_back(typed ? want : predicted);
    endtask

    // Receiver: stall pattern drawn from 32-bit words of ready bits, from always ready to mostly stalled
    logic [31:0] ready_word = '1;
    int          ready_bit = 0;
    always @(posedge i_clk) begin
        int unsigned pick;
        if (ready_bit == 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
                ready_word = '1;
            else if (pick < 60)
                ready_word = $urandom;
            else if (pick < 85)
                ready_word = $urandom | $urandom;
            else
                ready_word = $urandom & $urandom;
        end
        i_out_ready <= ready_word[ready_bit];
        ready_bit = (ready_bit + 1) % 32;
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_stats seen;
        t_stats want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen = {o_min_index, o_max_index, o_out_of_range_count, o_degenerate_count,
                    o_triangle_done, o_triangle_degenerate};
            if (pending_stats.size() == 0) begin
                flag_failure($sformatf("unexpected result: min %h max %h range %0d degen %0d",
                             seen.min_index, seen.max_index, seen.range_count,
                             seen.degen_count));
            end else begin
                want = pending_stats.pop_front();
                if (seen != want)
                    flag_failure($sformatf({"result mismatch: min %h/%h max %h/%h ",
                                 "range %0d/%0d degen %0d/%0d done %b/%b tri %b/%b ",
                                 "(expected/actual)"},
                                 want.min_index, seen.min_index, want.max_index,
                                 seen.max_index, want.range_count, seen.range_count,
                                 want.degen_count, seen.degen_count, want.done, seen.done,
                                 want.degenerate, seen.degenerate));
            end
        end
    end

    initial begin
        #10_000_000;
        $display("[mesh_index_validator_unit] ERROR");
        $finish;
    end

    initial begin
        t_row               row;
        logic [IDX_W-1:0]   vc;
        logic               pa;
        logic [THR_W-1:0]   thr;
        int                 pick, sent, tris, trail, span, mult, step, k2, shape;
        logic [IDX_W-1:0]   vid [3];
        logic signed [31:0] pos [3][3];
        logic signed [31:0] anchor;

        vtx_count  = '0;
        pos_enable = 1'b1;
        area_limit = THR_RESET;
        clear_mesh_stats();

        // Reset defaults: vertex count 0, so every index is out of range
        row_idx(1, 32'd5, 0, 0, 0, 1, t_stats'{32'd5, 32'd5, 32'd1, 31'd0, 1'b0, 1'b0});
        row_idx(0, 32'd0, 1, 2, 3, 1, t_stats'{32'd0, 32'd5, 32'd2, 31'd0, 1'b0, 1'b0});
        row_idx(0, '1, -1, -1, -1, 1, t_stats'{32'd0, '1, 32'd3, 31'd0, 1'b1, 1'b0});
        // Repeated index closes a degenerate triangle
        row_idx(0, 32'd7, 0, 0, 0, 1, t_stats'{32'd0, '1, 32'd4, 31'd0, 1'b0, 1'b0});
        row_idx(0, 32'd7, 5, 6, 7, 1, t_stats'{32'd0, '1, 32'd5, 31'd0, 1'b0, 1'b0});
        row_idx(0, 32'd9, 8, 9, 4, 1, t_stats'{32'd0, '1, 32'd6, 31'd1, 1'b1, 1'b1});
        row_reg(CFG_VERTEX_COUNT, 63'd100);
        row_reg(CFG_SPARE, '1);
        // Collinear, extreme positions, range boundary, clear mid-triangle
        row_idx(1, 32'd10, 0, 0, 0);
        row_idx(0, 32'd20, 32'sh10000, 32'sh10000, 32'sh10000);
        row_idx(0, 32'd30, 32'sh20000, 32'sh20000, 32'sh20000);
        row_idx(0, 32'd99, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        row_idx(0, 32'd98, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
        row_idx(0, 32'd97, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        row_idx(0, 32'd100, 0, 0, 0);
        row_idx(1, 32'd1, 0, 0, 0);
        row_idx(0, 32'd2, 32'sh10000, 0, 0);
        row_idx(0, 32'd3, 0, 32'sh10000, 0);
        // Threshold of one: unit cross is degenerate, doubled cross is not
        row_reg(CFG_AREA_THRESHOLD, 63'd1);
        row_idx(1, 32'd4, 0, 0, 0);
        row_idx(0, 32'd5, 1, 0, 0);
        row_idx(0, 32'd6, 0, 1, 0);
        row_idx(0, 32'd7, 0, 0, 0);
        row_idx(0, 32'd8, 2, 0, 0);
        row_idx(0, 32'd9, 0, 1, 0);
        // No positions: a zero-area triangle with distinct indices passes
        row_reg(CFG_POSITIONS_AVL, 63'd0);
        row_reg(CFG_AREA_THRESHOLD, 63'd0);
        row_reg(CFG_VERTEX_COUNT, 63'hFFFF_FFFF);
        row_idx(1, 32'd0, 0, 0, 0, 1, t_stats'{32'd0, 32'd0, 32'd0, 31'd0, 1'b0, 1'b0});
        row_idx(0, 32'h7FFF_FFFF, 0, 0, 0, 1,
                t_stats'{32'd0, 32'h7FFF_FFFF, 32'd0, 31'd0, 1'b0, 1'b0});
        row_idx(0, 32'hFFFF_FFFE, 0, 0, 0, 1,
                t_stats'{32'd0, 32'hFFFF_FFFE, 32'd0, 31'd0, 1'b1, 1'b0});

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table
        foreach (stim_table[n]) begin
            row = stim_table[n];
            if (row.is_reg)
                write_reg(row.reg_index, row.reg_value);
            else
                send_request(row.first, row.vindex, row.px, row.py, row.pz, row.typed, row.want);
        end

        for (int p = 0; p < PHASES; p++) begin
            // Pick this phase's registers; the first two pin the extremes
            if (p == 0) begin
                vc  = '1;
                pa  = 1'b1;
                thr = '1;
            end else if (p == 1) begin
                vc  = $urandom_range(3, 64);
                pa  = 1'b1;
                thr = '0;
            end else begin
                pick = $urandom_range(0, 9);
                if (pick < 6)
                    vc = $urandom_range(3, 64);
                else if (pick < 8)
                    vc = $urandom_range(65, 5000);
                else
                    vc = $urandom;
                pa = $urandom_range(0, 4) != 0;
                pick = $urandom_range(0, 4);
                thr = '0;
                if (pick == 0)
                    thr = THR_RESET;
                else if (pick == 1)
                    thr[$urandom_range(0, THR_W - 1)] = 1'b1;
                else if (pick == 2)
                    thr = THR_W'({$urandom, $urandom});
                else if (pick == 3)
                    thr = THR_W'($urandom_range(0, 255));
                else
                    thr = THR_RESET << $urandom_range(0, 20);
            end
            write_reg(CFG_VERTEX_COUNT, CFG_DATA_W'(vc));
            write_reg(CFG_POSITIONS_AVL, CFG_DATA_W'(pa));
            write_reg(CFG_AREA_THRESHOLD, thr);
            if (p == 2)
                write_reg(CFG_SPARE, CFG_DATA_W'({$urandom, $urandom}));

            // Stream whole meshes, with leftover indices now and then
            sent = 0;
            while (sent < RANDOM_ITEMS / PHASES) begin
                tris = $urandom_range(1, 12);
                for (int t = 0; t < tris; t++) begin
                    for (int k = 0; k < 3; k++)
                        vid[k] = rand_index();
                    if ($urandom_range(0, 6) == 0) begin
                        k2 = $urandom_range(0, 2);
                        vid[k2] = vid[(k2 + 1) % 3];
                    end
                    shape = $urandom_range(0, 19);
                    span  = $urandom_range(0, 16);
                    mult  = int'($urandom_range(0, 6)) - 3;
                    for (int c = 0; c < 3; c++) begin
                        anchor = $urandom;
                        step   = int'($urandom_range(0, 2 << span)) - (1 << span);
                        if (shape < 3) begin
                            pos[0][c] = $urandom;
                            pos[1][c] = $urandom;
                            pos[2][c] = $urandom;
                        end else if (shape < 6) begin
                            pos[0][c] = CORNER_VALUES[$urandom_range(0, 4)];
                            pos[1][c] = CORNER_VALUES[$urandom_range(0, 4)];
                            pos[2][c] = CORNER_VALUES[$urandom_range(0, 4)];
                        end else if (shape < 11) begin
                            // collinear: third vertex on the line through the first two
                            pos[0][c] = anchor;
                            pos[1][c] = anchor + step;
                            pos[2][c] = anchor + mult * step;
                        end else begin
                            // small triangle around the anchor
                            pos[0][c] = anchor;
                            pos[1][c] = anchor + step;
                            pos[2][c] = anchor + int'($urandom_range(0, 2 << span))
                                        - (1 << span);
                        end
                    end
                    for (int k = 0; k < 3; k++)
                        send_request((t == 0 && k == 0) || $urandom_range(0, 199) == 0,
                                     vid[k], pos[k][0], pos[k][1], pos[k][2], 1'b0, '0);
                    sent += 3;
                end
                if ($urandom_range(0, 3) == 0) begin
                    trail = $urandom_range(1, 2);
                    repeat (trail)
                        send_request(1'b0, rand_index(), $urandom, $urandom, $urandom,
                                     1'b0, '0);
                    sent += trail;
                end
            end
        end

        wait_for_results();
        repeat (SETTLE_TAIL) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("[mesh_index_validator_unit] OK");
        else
            $display("[mesh_index_validator_unit] ERROR");
        $finish;
    end

endmodule

// ===== mesh_index_validator_unit.f =====
design/miv_pkg.sv
design/miv_front.sv
design/miv_queue.sv
design/miv_back.sv
design/mesh_index_validator_unit.sv
design/miv_checker.sv
dv/mesh_index_validator_unit_tb.sv
